// ----- design/assert_macros.svh -----
// Assertion macros shared by the shape function evaluator RTL.
// Each macro checks one clocked implication with reset masking.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/h20sf_pkg.sv -----
// Package for the 20-node hexahedron shape function evaluator.
// Holds field widths, node table and control types; no dependencies.
`timescale 1ns / 1ps

package h20sf_pkg;

  localparam int COORD_W    = 16;
  localparam int WEIGHT_W   = 16;
  localparam int NODE_W     = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic [NODE_W-1:0] NODE_LAST = 5'd19;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 16'sh7FFF;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 16'sh8000;

  localparam logic [1:0] AXIS_S = 2'd0;
  localparam logic [1:0] AXIS_T = 2'd1;
  localparam logic [1:0] AXIS_U = 2'd2;

  // pos bit i set: factor (1 + x_i), clear: (1 - x_i); axis is the quadratic
  // direction of a mid-edge node
  typedef struct packed {
    logic       is_edge;
    logic [1:0] axis;
    logic [2:0] pos;
  } node_info_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              is_edge;
    logic              neg;
    logic              last;
  } node_ctl_t;

  function automatic node_info_t node_info(input logic [NODE_W-1:0] n);
    node_info_t r;
    r = '0;
    case (n)
      5'd0:  r = '{1'b0, AXIS_S, 3'b000};
      5'd1:  r = '{1'b0, AXIS_S, 3'b001};
      5'd2:  r = '{1'b0, AXIS_S, 3'b011};
      5'd3:  r = '{1'b0, AXIS_S, 3'b010};
      5'd4:  r = '{1'b0, AXIS_S, 3'b100};
      5'd5:  r = '{1'b0, AXIS_S, 3'b101};
      5'd6:  r = '{1'b0, AXIS_S, 3'b111};
      5'd7:  r = '{1'b0, AXIS_S, 3'b110};
      5'd8:  r = '{1'b1, AXIS_S, 3'b000};
      5'd9:  r = '{1'b1, AXIS_T, 3'b001};
      5'd10: r = '{1'b1, AXIS_S, 3'b010};
      5'd11: r = '{1'b1, AXIS_T, 3'b000};
      5'd12: r = '{1'b1, AXIS_S, 3'b100};
      5'd13: r = '{1'b1, AXIS_T, 3'b101};
      5'd14: r = '{1'b1, AXIS_S, 3'b110};
      5'd15: r = '{1'b1, AXIS_T, 3'b100};
      5'd16: r = '{1'b1, AXIS_U, 3'b000};
      5'd17: r = '{1'b1, AXIS_U, 3'b001};
      5'd18: r = '{1'b1, AXIS_U, 3'b011};
      5'd19: r = '{1'b1, AXIS_U, 3'b010};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/h20sf_front.sv -----
// Front end: clamps the coordinate triple and forms the linear factors
// (1+x), (1-x) and |x| per axis. Uses h20sf_pkg.
`timescale 1ns / 1ps

module h20sf_front
  import h20sf_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  localparam int ENT_W = 3 * (4 * FRAC_BITS + 7)
) (
  input  logic signed [COORD_W-1:0] coord_s,
  input  logic signed [COORD_W-1:0] coord_t,
  input  logic signed [COORD_W-1:0] coord_u,
  output logic [ENT_W-1:0]          entry
);

  localparam int CW    = FRAC_BITS + 2;
  localparam int FAC_W = FRAC_BITS + 2;
  localparam int MAG_W = FRAC_BITS + 1;
  localparam int AX_W  = CW + 2 * FAC_W + MAG_W;
  localparam int IW    = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;

  localparam logic signed [IW-1:0] ONE_I = IW'(1) << FRAC_BITS;
  localparam logic signed [CW:0]   ONE_C = (CW + 1)'(1) << FRAC_BITS;

  logic signed [COORD_W-1:0] raw [3];

  assign raw[0] = coord_s;
  assign raw[1] = coord_t;
  assign raw[2] = coord_u;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [IW-1:0] ext;
    logic signed [IW-1:0] clp;
    logic signed [CW-1:0] c;
    logic signed [CW:0]   sum_p;
    logic signed [CW:0]   sum_m;
    logic signed [CW:0]   absv;

    assign ext = {{(IW - COORD_W){raw[i][COORD_W-1]}}, raw[i]};
    assign clp = (ext > ONE_I) ? ONE_I : ((ext < -ONE_I) ? -ONE_I : ext);
    assign c   = clp[CW-1:0];

    assign sum_p = ONE_C + {c[CW-1], c};
    assign sum_m = ONE_C - {c[CW-1], c};
    assign absv  = c[CW-1] ? -{c[CW-1], c} : {c[CW-1], c};

    // lowest first: coordinate, 1+x, 1-x, |x|
    assign entry[i*AX_W +: AX_W] = {absv[MAG_W-1:0], sum_m[FAC_W-1:0],
                                    sum_p[FAC_W-1:0], c};
  end

endmodule

// ----- design/h20sf_fifo.sv -----
// Two-entry queue between the front end and the node sequencer.
// Generic payload width; no package dependency.
`timescale 1ns / 1ps

module h20sf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- design/h20sf_back.sv -----
// Back end: steps through the twenty nodes of the queued triple and runs
// each through a four-stage multiply/round pipeline. Uses h20sf_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module h20sf_back
  import h20sf_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  localparam int ENT_W = 3 * (4 * FRAC_BITS + 7)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  logic [ENT_W-1:0]           head_data,
  output logic                       head_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [NODE_W-1:0]          out_node,
  output logic signed [WEIGHT_W-1:0] out_weight,
  output logic                       out_last
);

  localparam int CW    = FRAC_BITS + 2;
  localparam int FAC_W = FRAC_BITS + 2;
  localparam int MAG_W = FRAC_BITS + 1;
  localparam int AX_W  = CW + 2 * FAC_W + MAG_W;
  localparam int DW    = FRAC_BITS + 4;
  localparam int OPW   = FRAC_BITS + 3;
  localparam int PW    = 2 * OPW;
  localparam int XW    = (OPW > 17) ? OPW : 17;

  localparam logic [OPW-1:0]        ONE_O   = OPW'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0]  TWO_D   = DW'(1) << (FRAC_BITS + 1);
  localparam logic [PW:0]           HALF_F  = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0]           HALF_F2 = (PW + 1)'(1) << (FRAC_BITS + 1);
  localparam logic [PW:0]           HALF_F3 = (PW + 1)'(1) << (FRAC_BITS + 2);
  localparam logic [XW-1:0]         POS_LIM = XW'(32767);
  localparam logic [XW-1:0]         NEG_LIM = XW'(32768);

  // ---------------- issue: node sequencer and operand select
  logic [NODE_W-1:0] node_cnt_r;
  logic [NODE_W-1:0] node_cnt_nxt;
  logic              adv;
  logic              issue;
  node_info_t        info;

  logic signed [CW-1:0] crd   [3];
  logic [FAC_W-1:0]     lin   [3];
  logic [MAG_W-1:0]     mag   [3];
  logic signed [DW-1:0] sc    [3];

  logic signed [DW-1:0] dsum;
  logic signed [DW-1:0] dabs;
  logic [OPW-1:0]       op_a, op_b, op_c, op_d;
  node_ctl_t            ctl0;

  assign adv      = !out_tvalid || out_tready;
  assign issue    = adv && head_valid;
  assign head_pop = issue && (node_cnt_r == NODE_LAST);
  assign info     = node_info(node_cnt_r);

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    logic [FAC_W-1:0] fp;
    logic [FAC_W-1:0] fm;
    assign crd[i] = head_data[i*AX_W +: CW];
    assign fp     = head_data[i*AX_W + CW +: FAC_W];
    assign fm     = head_data[i*AX_W + CW + FAC_W +: FAC_W];
    assign mag[i] = head_data[i*AX_W + CW + 2*FAC_W +: MAG_W];
    assign lin[i] = info.pos[i] ? fp : fm;
    assign sc[i]  = info.pos[i] ? {{(DW - CW){crd[i][CW-1]}}, crd[i]}
                                : -{{(DW - CW){crd[i][CW-1]}}, crd[i]};
  end

  assign dsum = sc[0] + sc[1] + sc[2] - TWO_D;
  assign dabs = dsum[DW-1] ? -dsum : dsum;

  always_comb begin
    ctl0.node    = node_cnt_r;
    ctl0.is_edge = info.is_edge;
    ctl0.neg     = !info.is_edge && dsum[DW-1];
    ctl0.last    = (node_cnt_r == NODE_LAST);
    if (!info.is_edge) begin
      op_a = {1'b0, lin[0]};
      op_b = {1'b0, lin[1]};
      op_c = {1'b0, lin[2]};
      op_d = dabs[OPW-1:0];
    end else begin
      case (info.axis)
        AXIS_S: begin
          op_a = {2'b00, mag[0]};
          op_c = {1'b0, lin[1]};
          op_d = {1'b0, lin[2]};
        end
        AXIS_T: begin
          op_a = {2'b00, mag[1]};
          op_c = {1'b0, lin[0]};
          op_d = {1'b0, lin[2]};
        end
        default: begin
          op_a = {2'b00, mag[2]};
          op_c = {1'b0, lin[0]};
          op_d = {1'b0, lin[1]};
        end
      endcase
      op_b = op_a;
    end
  end

  assign node_cnt_nxt = (node_cnt_r == NODE_LAST) ? '0 : node_cnt_r + 1'b1;

  // ---------------- pipeline registers
  logic            s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  node_ctl_t       s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r;
  logic [OPW-1:0]  s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  logic [PW-1:0]   s2_prod_r;
  logic [OPW-1:0]  s2_c_r, s2_d_r;
  logic [PW-1:0]   s3_prod_r;
  logic [OPW-1:0]  s3_d_r;
  logic [PW-1:0]   s4_prod_r;
  logic            out_valid_r;
  logic [NODE_W-1:0]          out_node_r;
  logic signed [WEIGHT_W-1:0] out_weight_r;
  logic                       out_last_r;

  // stage 2 -> 3: round first product; edge nodes take 1 - x^2
  logic [PW:0]    x1_sum;
  logic [OPW-1:0] x1;
  logic [OPW-1:0] v2;
  // stage 3 -> 4: corner applies the 1/8 here
  logic [PW:0]    x2_sum;
  logic [OPW-1:0] x2;
  // stage 4 -> out: edge applies the 1/4 here
  logic [PW:0]    x3_sum;
  logic [OPW-1:0] x3;
  logic [XW-1:0]  x3e;
  logic signed [WEIGHT_W-1:0] weight_nxt;

  assign x1_sum = {1'b0, s2_prod_r} + HALF_F;
  assign x1     = OPW'(x1_sum >> FRAC_BITS);
  assign v2     = s2_ctl_r.is_edge ? ONE_O - x1 : x1;

  assign x2_sum = {1'b0, s3_prod_r} + (s3_ctl_r.is_edge ? HALF_F : HALF_F3);
  assign x2     = s3_ctl_r.is_edge ? OPW'(x2_sum >> FRAC_BITS)
                                   : OPW'(x2_sum >> (FRAC_BITS + 3));

  assign x3_sum = {1'b0, s4_prod_r} + (s4_ctl_r.is_edge ? HALF_F2 : HALF_F);
  assign x3     = s4_ctl_r.is_edge ? OPW'(x3_sum >> (FRAC_BITS + 2))
                                   : OPW'(x3_sum >> FRAC_BITS);
  assign x3e    = XW'(x3);

  always_comb begin
    if (s4_ctl_r.neg) begin
      weight_nxt = (x3e > NEG_LIM) ? WEIGHT_MIN : WEIGHT_W'(-x3e);
    end else begin
      weight_nxt = (x3e > POS_LIM) ? WEIGHT_MAX : x3e[WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r  <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (issue) begin
        node_cnt_r <= node_cnt_nxt;
      end
      s1_valid_r  <= issue;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // payload: whole pipe moves together, stalls with the output beat
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r     <= ctl0;
      s1_a_r       <= op_a;
      s1_b_r       <= op_b;
      s1_c_r       <= op_c;
      s1_d_r       <= op_d;
      s2_ctl_r     <= s1_ctl_r;
      s2_prod_r    <= PW'(s1_a_r) * PW'(s1_b_r);
      s2_c_r       <= s1_c_r;
      s2_d_r       <= s1_d_r;
      s3_ctl_r     <= s2_ctl_r;
      s3_prod_r    <= PW'(v2) * PW'(s2_c_r);
      s3_d_r       <= s2_d_r;
      s4_ctl_r     <= s3_ctl_r;
      s4_prod_r    <= PW'(x2) * PW'(s3_d_r);
      out_node_r   <= s4_ctl_r.node;
      out_last_r   <= s4_ctl_r.last;
      out_weight_r <= weight_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_node   = out_node_r;
  assign out_weight = out_weight_r;
  assign out_last   = out_last_r;

  `ASSERT_IMPLY(a_last_flag, clk, rst_n, out_valid_r, out_last_r == (out_node_r == NODE_LAST))
  `ASSERT_IMPLY(a_cnt_range, clk, rst_n, 1'b1, node_cnt_r <= NODE_LAST)
  `ASSERT_NEXT(a_pipe_adv, clk, rst_n, s1_valid_r && adv, s2_valid_r)

endmodule

// ----- design/hex20_shape_function_eval_top.sv -----
// 20-node hexahedron shape functions: one (s,t,u) beat in, twenty node beats out.
// Throughput: one node per cycle while out_tready does not stall the output,
// through a single shared four-stage multiply pipeline; a two-entry queue
// holds waiting triples.
// Reset: synchronous, active low; clears queue, node counter and valid flags.
`timescale 1ns / 1ps

module hex20_shape_function_eval_top
  import h20sf_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] coord_s, [31:16] coord_t, [47:32] coord_u
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [4:0] node_index, [20:5] weight, [23:21] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int ENT_W = 3 * (4 * FRAC_BITS + 7);

  logic [ENT_W-1:0]           entry;
  logic [ENT_W-1:0]           head_data;
  logic                       head_valid;
  logic                       head_pop;
  logic                       q_full;
  logic [NODE_W-1:0]          out_node;
  logic signed [WEIGHT_W-1:0] out_weight;

  assign in_tready = !q_full;

  h20sf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .coord_s (in_tdata[15:0]),
    .coord_t (in_tdata[31:16]),
    .coord_u (in_tdata[47:32]),
    .entry   (entry)
  );

  h20sf_fifo #(.WIDTH(ENT_W)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid && in_tready),
    .wr_data    (entry),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  h20sf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .head_pop   (head_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_node   (out_node),
    .out_weight (out_weight),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W - NODE_W - WEIGHT_W){1'b0}}, out_weight, out_node};

endmodule
